### rtl/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every rising edge, held off while reset is asserted
`define IRL_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("irl assertion failed");

// condition that must never be seen outside reset
`define IRL_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `IRL_ASSERT(lbl, clk, rstn, !(cond))

`else

`define IRL_ASSERT(lbl, clk, rstn, prop)

`define IRL_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

### rtl/irl_pkg.sv
`timescale 1ns / 1ps

package irl_pkg;

  localparam int SumW     = 16;
  localparam int CountW   = 7;
  localparam int DistW    = 7;
  localparam int DigitW   = 4;
  localparam int McandW   = 8;
  localparam int RecipW   = 17;
  localparam int ProdW    = 25;
  localparam int StepW    = 4;
  localparam int NumSeg   = 7;
  localparam int BpW      = 9;
  localparam int SegIdxW  = 3;
  localparam int CeilBits = 16;

  localparam logic [SumW-1:0]  LowLimit  = 16'd80;
  localparam logic [SumW-1:0]  HighLimit = 16'd490;
  localparam logic [DistW-1:0] LowDist   = 7'd80;
  localparam logic [DistW-1:0] HighDist  = 7'd10;
  localparam logic [CountW-1:0] CountRst = 7'd20;

  // segment breakpoints, bases and q16 reciprocals of the segment slopes
  localparam logic [BpW-1:0] SegBp [NumSeg+1] = '{
    9'd80, 9'd87, 9'd106, 9'd124, 9'd150, 9'd196, 9'd276, 9'd490
  };
  localparam logic [DistW-1:0] SegBase [NumSeg] = '{
    7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20
  };
  localparam logic [RecipW-1:0] SegRecip [NumSeg] = '{
    17'd85112, 17'd31059, 17'd32768, 17'd22756, 17'd12825, 17'd7380, 17'd2757
  };

  typedef struct packed {
    logic              start_div;
    logic              start_mul;
    logic [SumW-1:0]   dividend;
    logic [CountW-1:0] divisor;
    logic [McandW-1:0] mcand;
    logic [RecipW-1:0] recip;
  } unit_cmd_t;

  typedef struct packed {
    logic             done;
    logic [ProdW-1:0] result;
  } unit_rsp_t;

  // tens and ones of a small distance, by compares against multiples of ten
  function automatic logic [2*DigitW-1:0] to_digits(input logic [DistW-1:0] d);
    logic [DigitW-1:0] t;
    logic [DistW-1:0]  r;
    t = '0;
    for (int i = 1; i <= 12; i++) begin
      if (d >= DistW'(10 * i)) begin
        t = DigitW'(i);
      end
    end
    r = d - DistW'(t) * DistW'(10);
    return {t, r[DigitW-1:0]};
  endfunction

endpackage

### rtl/ir_range_average_linearize.sv
// channel   direction  transfer when               payload
// cfg       in         cfg_valid_i & cfg_ready_o    cfg_sample_count_i
// in        in         in_valid_i & !in_stall_o     sample_i
// out       out        out_valid_o & !out_stall_i   distance_cm_o, tens_digit_o, ones_digit_o
//
// a sample that does not close a block is added to the running sum
// a closing sample reaches the output register through states S_DIV (16 divide steps on
// the shared adder), S_SEG, S_MUL (8 multiply steps on the same adder) and S_OUT; S_MUL
// is skipped when the average is at or below the low limit or at or above the high limit
// the input stalls meanwhile, and longer while the previous result sits in a stalled output
// asynchronous active-low reset; sample count comes up as 20, sum and held distance as zero
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ir_range_average_linearize #(
  parameter int ADC_BITS    = 10,
  parameter int MAX_SAMPLES = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irl_pkg::CountW-1:0]    cfg_sample_count_i,
  // sample input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ADC_BITS-1:0]           sample_i,
  // distance output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [irl_pkg::DistW-1:0]     distance_cm_o,
  output logic [irl_pkg::DigitW-1:0]    tens_digit_o,
  output logic [irl_pkg::DigitW-1:0]    ones_digit_o
);

  localparam int CntW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam logic [irl_pkg::CountW-1:0] MaxCnt = irl_pkg::CountW'(MAX_SAMPLES);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIV  = 5'b00010,
    S_SEG  = 5'b00100,
    S_MUL  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e                              state_q, state_d;
  logic [irl_pkg::CountW-1:0]          count_cfg_q;
  logic [irl_pkg::SumW-1:0]            sum_q, sum_d;
  logic [CntW-1:0]                     taken_q, taken_d;
  logic [irl_pkg::DistW-1:0]           last_q, last_d;
  logic [irl_pkg::DistW-1:0]           dist_q, dist_d;
  logic [irl_pkg::SegIdxW-1:0]         seg_q, seg_d;

  logic                                out_valid_q, out_valid_d;
  logic [irl_pkg::DistW-1:0]           out_dist_q, out_dist_d;
  logic [irl_pkg::DigitW-1:0]          out_tens_q, out_tens_d;
  logic [irl_pkg::DigitW-1:0]          out_ones_q, out_ones_d;

  irl_pkg::unit_cmd_t                  cmd;
  irl_pkg::unit_rsp_t                  rsp;

  logic                                in_xfer;
  logic                                out_free;
  logic [irl_pkg::CountW-1:0]          n_eff;
  logic [irl_pkg::SumW-1:0]            sum_new;
  logic                                closing;
  logic [irl_pkg::SumW-1:0]            avg;
  logic [irl_pkg::SegIdxW-1:0]         seg_find;
  logic [irl_pkg::CeilBits/2+1:0]      drop;
  logic [2*irl_pkg::DigitW-1:0]        digits;

  // iterative divide and multiply share one adder in here
  irl_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .rsp_o  (rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  // zero count means one, counts above the sample limit are clipped
  always_comb begin
    if (count_cfg_q == '0) begin
      n_eff = irl_pkg::CountW'(1);
    end else if (count_cfg_q > MaxCnt) begin
      n_eff = MaxCnt;
    end else begin
      n_eff = count_cfg_q;
    end
  end

  assign sum_new = sum_q + irl_pkg::SumW'(sample_i);
  // also closes early when the count was lowered under the samples taken
  assign closing = (irl_pkg::CountW'(taken_q) + irl_pkg::CountW'(1)) >= n_eff;

  // quotient sits in the low bits of the unit result after the divide
  assign avg = rsp.result[irl_pkg::SumW-1:0];

  // which linear segment holds the average
  always_comb begin
    seg_find = '0;
    for (int i = 0; i < irl_pkg::NumSeg; i++) begin
      if (avg >= irl_pkg::SumW'(irl_pkg::SegBp[i]) &&
          avg <  irl_pkg::SumW'(irl_pkg::SegBp[i+1])) begin
        seg_find = irl_pkg::SegIdxW'(i);
      end
    end
  end

  // ceiling of the q16 product
  assign drop = (irl_pkg::CeilBits/2+2)'(rsp.result[irl_pkg::ProdW-1:irl_pkg::CeilBits])
              + (irl_pkg::CeilBits/2+2)'(|rsp.result[irl_pkg::CeilBits-1:0]);

  assign digits = irl_pkg::to_digits(dist_q);

  always_comb begin
    state_d       = state_q;
    sum_d         = sum_q;
    taken_d       = taken_q;
    last_d        = last_q;
    dist_d        = dist_q;
    seg_d         = seg_q;
    out_valid_d   = out_valid_q;
    out_dist_d    = out_dist_q;
    out_tens_d    = out_tens_q;
    out_ones_d    = out_ones_q;
    cmd           = '0;
    cmd.dividend  = sum_new;
    cmd.divisor   = n_eff;
    cmd.mcand     = irl_pkg::McandW'(avg - irl_pkg::SumW'(irl_pkg::SegBp[seg_find]));
    cmd.recip     = irl_pkg::SegRecip[seg_find];

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (closing) begin
            cmd.start_div = 1'b1;
            sum_d         = '0;
            taken_d       = '0;
            state_d       = S_DIV;
          end else begin
            sum_d   = sum_new;
            taken_d = taken_q + CntW'(1);
          end
        end
      end
      S_DIV: begin
        if (rsp.done) begin
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        // low, exact-top and over-range averages skip the multiply
        priority if (avg <= irl_pkg::LowLimit) begin
          dist_d  = irl_pkg::LowDist;
          state_d = S_OUT;
        end else if (avg == irl_pkg::HighLimit) begin
          dist_d  = irl_pkg::HighDist;
          state_d = S_OUT;
        end else if (avg > irl_pkg::HighLimit) begin
          dist_d  = last_q;
          state_d = S_OUT;
        end else begin
          seg_d         = seg_find;
          cmd.start_mul = 1'b1;
          state_d       = S_MUL;
        end
      end
      S_MUL: begin
        if (rsp.done) begin
          dist_d  = irl_pkg::SegBase[seg_q] - drop[irl_pkg::DistW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // wait until the output register is free
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dist_d  = dist_q;
          out_tens_d  = digits[2*irl_pkg::DigitW-1:irl_pkg::DigitW];
          out_ones_d  = digits[irl_pkg::DigitW-1:0];
          last_d      = dist_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_cfg_q <= irl_pkg::CountRst;
      sum_q       <= '0;
      taken_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      taken_q     <= taken_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_cfg_q <= cfg_sample_count_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q     <= dist_d;
    seg_q      <= seg_d;
    out_dist_q <= out_dist_d;
    out_tens_q <= out_tens_d;
    out_ones_q <= out_ones_d;
  end

  assign out_valid_o   = out_valid_q;
  assign distance_cm_o = out_dist_q;
  assign tens_digit_o  = out_tens_q;
  assign ones_digit_o  = out_ones_q;

  `IRL_ASSERT(a_digits_match, clk_i, rst_ni, out_valid_o |-> (irl_pkg::DistW'(tens_digit_o) * irl_pkg::DistW'(10) + irl_pkg::DistW'(ones_digit_o)) == distance_cm_o)
  `IRL_ASSERT(a_dist_range, clk_i, rst_ni, out_valid_o |-> distance_cm_o <= irl_pkg::LowDist)
  `IRL_ASSERT_NEVER(a_done_unexpected, clk_i, rst_ni, rsp.done && (state_q == S_IDLE || state_q == S_OUT || state_q == S_SEG))

endmodule

### rtl/irl_iter_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module irl_iter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  irl_pkg::unit_cmd_t   cmd_i,
  output irl_pkg::unit_rsp_t   rsp_o
);

  localparam int AddW = irl_pkg::RecipW + 2;

  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_DIV  = 3'b010,
    U_MUL  = 3'b100
  } unit_state_e;

  unit_state_e                    state_q, state_d;
  logic [irl_pkg::StepW-1:0]      cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic [irl_pkg::ProdW-1:0]      work_q, work_d;
  logic [irl_pkg::RecipW-1:0]     opnd_q, opnd_d;

  logic [AddW-1:0]                add_a, add_b, add_res;
  logic                           add_cin;
  logic                           ge;
  logic [irl_pkg::CountW-1:0]     rem_new;

  // the one adder, shared by divide (trial subtract) and multiply (shift-add)
  always_comb begin
    unique case (state_q)
      U_DIV: begin
        add_a   = AddW'({work_q[irl_pkg::SumW +: irl_pkg::CountW],
                         work_q[irl_pkg::SumW-1]});
        add_b   = ~AddW'(opnd_q[irl_pkg::CountW-1:0]);
        add_cin = 1'b1;
      end
      U_MUL: begin
        add_a   = AddW'(work_q[irl_pkg::ProdW-1:irl_pkg::McandW]);
        add_b   = work_q[0] ? AddW'(opnd_q) : '0;
        add_cin = 1'b0;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
    add_res = add_a + add_b + AddW'(add_cin);
  end

  assign ge      = !add_res[AddW-1];
  assign rem_new = ge ? add_res[irl_pkg::CountW-1:0]
                      : {work_q[irl_pkg::SumW +: irl_pkg::CountW-1],
                         work_q[irl_pkg::SumW-1]};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    work_d  = work_q;
    opnd_d  = opnd_q;
    unique case (state_q)
      U_IDLE: begin
        if (cmd_i.start_div) begin
          work_d  = irl_pkg::ProdW'(cmd_i.dividend);
          opnd_d  = irl_pkg::RecipW'(cmd_i.divisor);
          cnt_d   = irl_pkg::StepW'(irl_pkg::SumW - 1);
          state_d = U_DIV;
        end else if (cmd_i.start_mul) begin
          work_d  = irl_pkg::ProdW'(cmd_i.mcand);
          opnd_d  = cmd_i.recip;
          cnt_d   = irl_pkg::StepW'(irl_pkg::McandW - 1);
          state_d = U_MUL;
        end
      end
      U_DIV, U_MUL: begin
        if (state_q == U_DIV) begin
          work_d = irl_pkg::ProdW'({rem_new, work_q[irl_pkg::SumW-2:0], ge});
        end else begin
          work_d = {add_res[irl_pkg::RecipW:0], work_q[irl_pkg::McandW-1:1]};
        end
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = U_IDLE;
        end else begin
          cnt_d = cnt_q - irl_pkg::StepW'(1);
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    opnd_q <= opnd_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = work_q;

  `IRL_ASSERT(a_start_when_idle, clk_i, rst_ni, (cmd_i.start_div || cmd_i.start_mul) |-> state_q == U_IDLE)
  `IRL_ASSERT_NEVER(a_two_starts, clk_i, rst_ni, cmd_i.start_div && cmd_i.start_mul)
  `IRL_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q)

endmodule
